// ===== rtl/mwc_pkg.sv =====
// shared types and constants for the multiply-with-carry generator
`default_nettype none

package mwc_pkg;

    localparam int DATA_W  = 32;
    localparam int HALF_W  = 16;
    localparam int SPAN_W  = DATA_W + 1;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam logic [HALF_W-1:0] MUL_Z = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_W = 16'd18000;

    localparam logic [DATA_W-1:0] SEED_MUL_W = 32'd2019164533;
    localparam logic [DATA_W-1:0] SEED_MUL_Z = 32'd1000632769;

    // lanes as seeded from zero
    localparam logic [DATA_W-1:0] LANE_Z_INIT = 32'd3294334527;
    localparam logic [DATA_W-1:0] LANE_W_INIT = 32'd2019164533;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        OP_RAW    = 2'd0,
        OP_RANGE  = 2'd1,
        OP_RESEED = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic capture;
        logic seed_load;
        logic lane_step;
        logic res_draw;
        logic res_low;
        logic div_start;
        logic div_step;
        logic res_mod;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_range;
        logic inverted;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/mwc_datapath.sv =====
// lanes, seed register, remainder divider and output register
`default_nettype none

module mwc_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mwc_pkg::cmd_t                cmd,
    output mwc_pkg::status_t                  status,
    input  wire logic [1:0]                   op,
    input  wire logic [mwc_pkg::DATA_W-1:0]   range_low,
    input  wire logic [mwc_pkg::DATA_W-1:0]   range_high,
    input  wire logic                         seed_wr,
    input  wire logic [mwc_pkg::DATA_W-1:0]   seed_data,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic [mwc_pkg::DATA_W-1:0]        value
);

    logic [mwc_pkg::DATA_W-1:0] seed_reg;
    logic [mwc_pkg::DATA_W-1:0] lane_z_reg, lane_z_next;
    logic [mwc_pkg::DATA_W-1:0] lane_w_reg, lane_w_next;
    logic                       out_valid_reg;
    logic [mwc_pkg::DATA_W-1:0] value_reg;

    logic                       is_range_reg;
    logic                       inverted_reg;
    logic [mwc_pkg::DATA_W-1:0] low_reg;
    logic [mwc_pkg::SPAN_W-1:0] span_reg;
    logic [mwc_pkg::DATA_W-1:0] res_reg;
    logic [mwc_pkg::DATA_W-1:0] rem_reg, rem_next;
    logic [mwc_pkg::DATA_W-1:0] quo_reg;
    logic [mwc_pkg::CNT_W-1:0]  div_cnt_reg;

    logic [mwc_pkg::DATA_W-1:0] z_prod, w_prod;
    logic [mwc_pkg::DATA_W-1:0] seed_w_odd, seed_z_odd;
    logic [mwc_pkg::DATA_W-1:0] seed_w_mix, seed_z_mix;
    logic [mwc_pkg::DATA_W-1:0] draw;
    logic [mwc_pkg::SPAN_W-1:0] rem_shift, rem_diff;

    // one lane step: mul * low half + high half
    assign z_prod = {{mwc_pkg::HALF_W{1'b0}}, mwc_pkg::MUL_Z}
                  * {{mwc_pkg::HALF_W{1'b0}}, lane_z_reg[mwc_pkg::HALF_W-1:0]};
    assign w_prod = {{mwc_pkg::HALF_W{1'b0}}, mwc_pkg::MUL_W}
                  * {{mwc_pkg::HALF_W{1'b0}}, lane_w_reg[mwc_pkg::HALF_W-1:0]};

    // odd-multiplier seed mixing
    assign seed_w_odd = {seed_reg[mwc_pkg::DATA_W-2:0], 1'b1};
    assign seed_z_odd = {~seed_reg[mwc_pkg::DATA_W-2:0], 1'b1};
    assign seed_w_mix = seed_w_odd * mwc_pkg::SEED_MUL_W;
    assign seed_z_mix = seed_z_odd * mwc_pkg::SEED_MUL_Z;

    always_comb
    begin
        lane_z_next = lane_z_reg;
        lane_w_next = lane_w_reg;
        if (cmd.seed_load)
        begin
            lane_z_next = seed_z_mix;
            lane_w_next = seed_w_mix;
        end
        else if (cmd.lane_step)
        begin
            lane_z_next = z_prod
                + {{mwc_pkg::HALF_W{1'b0}}, lane_z_reg[mwc_pkg::DATA_W-1:mwc_pkg::HALF_W]};
            lane_w_next = w_prod
                + {{mwc_pkg::HALF_W{1'b0}}, lane_w_reg[mwc_pkg::DATA_W-1:mwc_pkg::HALF_W]};
        end
    end

    assign draw = {lane_z_reg[mwc_pkg::HALF_W-1:0], {mwc_pkg::HALF_W{1'b0}}} + lane_w_reg;

    // restoring remainder step
    assign rem_shift = {rem_reg, quo_reg[mwc_pkg::DATA_W-1]};
    assign rem_diff  = rem_shift - span_reg;
    assign rem_next  = (rem_shift >= span_reg) ? rem_diff[mwc_pkg::DATA_W-1:0]
                                               : rem_shift[mwc_pkg::DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            lane_z_reg    <= mwc_pkg::LANE_Z_INIT;
            lane_w_reg    <= mwc_pkg::LANE_W_INIT;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (seed_wr)
            begin
                seed_reg <= seed_data;
            end
            lane_z_reg <= lane_z_next;
            lane_w_reg <= lane_w_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_range_reg <= (mwc_pkg::op_t'(op) == mwc_pkg::OP_RANGE);
            inverted_reg <= (range_low > range_high);
            low_reg      <= range_low;
            span_reg     <= {1'b0, range_high} - {1'b0, range_low} + 1'b1;
        end
        if (cmd.res_draw)
        begin
            res_reg <= draw;
        end
        else if (cmd.res_low)
        begin
            res_reg <= low_reg;
        end
        else if (cmd.res_mod)
        begin
            res_reg <= rem_reg + low_reg;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= draw;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[mwc_pkg::DATA_W-2:0], 1'b0};
        end
        if (cmd.out_load)
        begin
            value_reg <= res_reg;
        end
    end

    assign status.is_range = is_range_reg;
    assign status.inverted = inverted_reg;
    assign status.div_last = (div_cnt_reg == mwc_pkg::DIV_LAST);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ({1'b0, rem_reg} < span_reg))
        else $error("remainder reached the span");

    a_div_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (div_cnt_reg == '0))
        else $error("divider count not cleared at start");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(value_reg)))
        else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

// ===== rtl/mwc_controller.sv =====
// sequencing state machine for the generator
`default_nettype none

module mwc_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       op,
    output logic                  in_stall,
    input  wire mwc_pkg::status_t status,
    output mwc_pkg::cmd_t         cmd
);

    mwc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            mwc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (mwc_pkg::op_t'(op)) inside
                        mwc_pkg::OP_RAW, mwc_pkg::OP_RANGE: state_next = mwc_pkg::ST_STEP;
                        mwc_pkg::OP_RESEED:                 state_next = mwc_pkg::ST_SEED;
                        default:                            state_next = mwc_pkg::ST_IDLE;
                    endcase
                end
            end
            mwc_pkg::ST_SEED:
            begin
                cmd.seed_load = 1'b1;
                state_next    = mwc_pkg::ST_IDLE;
            end
            mwc_pkg::ST_STEP:
            begin
                cmd.lane_step = 1'b1;
                state_next    = mwc_pkg::ST_PREP;
            end
            mwc_pkg::ST_PREP:
            begin
                if (!status.is_range)
                begin
                    cmd.res_draw = 1'b1;
                    state_next   = mwc_pkg::ST_DELIVER;
                end
                else if (status.inverted)
                begin
                    cmd.res_low = 1'b1;
                    state_next  = mwc_pkg::ST_DELIVER;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = mwc_pkg::ST_DIV;
                end
            end
            mwc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = mwc_pkg::ST_FIN;
                end
            end
            mwc_pkg::ST_FIN:
            begin
                cmd.res_mod = 1'b1;
                state_next  = mwc_pkg::ST_DELIVER;
            end
            mwc_pkg::ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwc_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output loaded while occupied");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwc_pkg::ST_DIV && status.div_last) |=> (state_reg == mwc_pkg::ST_FIN))
        else $error("divider did not finish after last step");

    a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall
         && (mwc_pkg::op_t'(op) == mwc_pkg::OP_RAW || mwc_pkg::op_t'(op) == mwc_pkg::OP_RANGE))
        |=> (state_reg == mwc_pkg::ST_STEP))
        else $error("draw request did not start a lane step");

endmodule

`default_nettype wire

// ===== rtl/mwc_random_generator_core.sv =====
// top level of the two-lane multiply-with-carry random generator
// usage:
//   input channel (in_valid / in_stall) carries one request: op, range_low, range_high
//     op raw    : one draw, result is (z << 16) + w
//     op range  : one draw, result is range_low + draw mod (range_high - range_low + 1),
//                 or range_low when the range is inverted
//     op reseed : both lanes reloaded from the seed register, no result
//     op 3      : ignored, no result
//   output channel (out_valid / out_stall) carries value
//   config channel (cfg_valid / cfg_ready) writes the seed register; cfg_ready is always high
// timing:
//   one request at a time; in_stall is low only while the sequencer is idle
//   raw draw and inverted range: lane step, result select, then load into the output register once free
//   range draw: lane step, the 32-step restoring remainder divider (one bit per cycle),
//   then the final add and the load into the output register once free
//   reseed: both lanes are reloaded before the next request is taken
// output register separates the sides: a new request is taken while a result waits;
// its own result then holds in the result register until the receiver stops stalling
// reset: lanes return to the zero-seed state, seed register clears, no result pending
`default_nettype none

module mwc_random_generator_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 op,
    input  wire logic [mwc_pkg::DATA_W-1:0] range_low,
    input  wire logic [mwc_pkg::DATA_W-1:0] range_high,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [mwc_pkg::DATA_W-1:0]      value,
    // seed register write
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [mwc_pkg::DATA_W-1:0] cfg_data
);

    mwc_pkg::cmd_t    cmd;
    mwc_pkg::status_t status;

    // seed writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: decodes the request and steps the datapath
    mwc_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // lanes, divider and output register
    mwc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .op         (op),
        .range_low  (range_low),
        .range_high (range_high),
        .seed_wr    (cfg_valid && cfg_ready),
        .seed_data  (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .value      (value)
    );

endmodule

`default_nettype wire
